FILE: hdl/bts_pkg.sv
// Shared types and constants for the block transfer sequencer.
package bts_pkg;

  // Default depth of the queue between the front and back parts
  localparam int BTS_QDEPTH = 2;

  localparam logic [3:0]  BTS_PC_REG     = 4'd15;
  localparam logic [15:0] BTS_PC_ONLY    = 16'h8000;
  localparam logic [31:0] BTS_ALIGN_MASK = 32'hFFFF_FFFC;
  localparam logic [31:0] BTS_WORD_STEP  = 32'd4;

  // Start and final offsets are small signed values relative to the base
  localparam logic signed [7:0] BTS_OFF_ZERO     = 8'sd0;
  localparam logic signed [7:0] BTS_OFF_WORD     = 8'sd4;
  localparam logic signed [7:0] BTS_OFF_BLOCK    = 8'sd64;   // 0x40
  localparam logic signed [7:0] BTS_OFF_DA_EMPTY = -8'sd60;  // -0x3c

  localparam logic [2:0] BTS_PC_ADD_ARM   = 3'd4;
  localparam logic [2:0] BTS_PC_ADD_THUMB = 3'd2;
  localparam logic [2:0] BTS_PC_ADD_NONE  = 3'd0;

  // One classified instruction, as handed from front to back
  typedef struct packed {
    logic [15:0] mask;        // registers to move, bit-reversed when descending
    logic        descending;  // highest register first, falling addresses
    logic [31:0] start;       // address of the first transaction
    logic [31:0] fin;         // final base value
    logic        is_load;
    logic        ubank;
    logic [3:0]  rn;
    logic        snb_en;      // store of the base substitutes the new base
    logic        thumb;
    logic        bupd;
    logic        rstat;
    logic        flush;
  } bts_desc_t;

endpackage

FILE: hdl/block_transfer_sequencer_top.sv
// The first transaction passes the descriptor queue, the back instruction register
// and the output register. One transaction per cycle while the output is popped;
// n listed registers (an empty list counts as one) give n transactions.
// A descriptor queue lets the front accept instructions while the back works.
// Reset (synchronous) empties the queue and output register; empty is high after.
// Top level: front decoder, descriptor queue and back sequencer.
module block_transfer_sequencer_top #(
  parameter int QDEPTH = bts_pkg::BTS_QDEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        is_load,
  input  logic        pre_index,
  input  logic        step_up,
  input  logic        s_bit,
  input  logic        write_back,
  input  logic [3:0]  base_reg,
  input  logic [15:0] reg_list,
  input  logic [31:0] base_value,
  input  logic        thumb_mode,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] mem_addr,
  output logic [3:0]  reg_index,
  output logic        load_dir,
  output logic        user_bank,
  output logic        store_new_base,
  output logic [2:0]  pc_add,
  output logic [31:0] final_base,
  output logic        base_update,
  output logic        restore_status,
  output logic        flush_pipe,
  output logic        last
);
  import bts_pkg::*;

  bts_desc_t front_desc;
  bts_desc_t q_data;
  logic      q_empty;
  logic      q_pop;
  logic      accept;

  assign accept = push && !full;

  // Classify the incoming instruction
  bts_front u_front (
    .is_load    (is_load),
    .pre_index  (pre_index),
    .step_up    (step_up),
    .s_bit      (s_bit),
    .write_back (write_back),
    .base_reg   (base_reg),
    .reg_list   (reg_list),
    .base_value (base_value),
    .thumb_mode (thumb_mode),
    .desc       (front_desc)
  );

  // Buffer descriptors between front and back
  bts_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_desc),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // Issue the transactions
  bts_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_data         (q_data),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .mem_addr       (mem_addr),
    .reg_index      (reg_index),
    .load_dir       (load_dir),
    .user_bank      (user_bank),
    .store_new_base (store_new_base),
    .pc_add         (pc_add),
    .final_base     (final_base),
    .base_update    (base_update),
    .restore_status (restore_status),
    .flush_pipe     (flush_pipe),
    .last           (last)
  );

`ifndef SYNTHESIS
  // Reset leaves nothing to deliver and room to accept
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("output or queue not clear after reset");

  // A non-final transaction is followed at once by the next of the same instruction
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> (!empty && $stable(final_base)))
    else $error("gap or instruction change inside a block transfer");

  // PC offset only on a store of R15
  a_pc_add: assert property (@(posedge clk) disable iff (rst)
    (!empty && pc_add != BTS_PC_ADD_NONE) |-> (!load_dir && reg_index == BTS_PC_REG))
    else $error("pc_add set on a transaction that is not a store of R15");
`endif

endmodule

FILE: hdl/bts_front.sv
// Front part: decodes one instruction into a transfer descriptor.
module bts_front (
  input  logic              is_load,
  input  logic              pre_index,
  input  logic              step_up,
  input  logic              s_bit,
  input  logic              write_back,
  input  logic [3:0]        base_reg,
  input  logic [15:0]       reg_list,
  input  logic [31:0]       base_value,
  input  logic              thumb_mode,
  output bts_pkg::bts_desc_t desc
);
  import bts_pkg::*;

  logic [15:0]       eff;
  logic [15:0]       rev;
  logic              empty_list;
  logic              has_pc;
  logic              has_base;
  logic [4:0]        cnt;
  logic [3:0]        lowest;
  logic signed [7:0] span;
  logic signed [7:0] start_off;
  logic signed [7:0] fin_off;
  logic              descending;

  // Count listed registers and find the lowest one
  always_comb begin
    cnt    = 5'd0;
    lowest = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (eff[i]) begin
        cnt    = cnt + 5'd1;
        lowest = 4'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      rev[i] = eff[15 - i];
    end
  end

  assign empty_list = (reg_list == 16'd0);
  assign eff        = empty_list ? BTS_PC_ONLY : reg_list;
  assign has_pc     = reg_list[15];
  assign has_base   = eff[base_reg];
  assign span       = $signed({1'b0, cnt, 2'b00});

  // Pick start and final offsets per addressing mode
  always_comb begin
    descending = 1'b0;
    start_off  = BTS_OFF_ZERO;
    fin_off    = step_up ? span : -span;
    if (!pre_index && step_up) begin
      start_off = BTS_OFF_ZERO;
    end else if (pre_index && step_up) begin
      if (is_load) begin
        start_off  = span;
        descending = 1'b1;
      end else begin
        start_off = BTS_OFF_WORD;
      end
    end else if (!pre_index && !step_up) begin
      if (empty_list) begin
        start_off = BTS_OFF_DA_EMPTY;
      end else if (is_load) begin
        start_off = BTS_OFF_WORD - span;
      end else begin
        start_off = BTS_OFF_ZERO;
      end
      descending = !is_load;
    end else begin
      start_off = empty_list ? -BTS_OFF_BLOCK : -span;
    end
    if (empty_list) begin
      fin_off = step_up ? BTS_OFF_BLOCK : -BTS_OFF_BLOCK;
    end
  end

  // Assemble the descriptor
  always_comb begin
    desc.mask       = descending ? rev : eff;
    desc.descending = descending;
    desc.start      = base_value + {{24{start_off[7]}}, start_off};
    desc.fin        = base_value + {{24{fin_off[7]}}, fin_off};
    desc.is_load    = is_load;
    desc.ubank      = is_load ? (s_bit && !has_pc) : s_bit;
    desc.rn         = base_reg;
    desc.snb_en     = !is_load && has_base && (base_reg != lowest);
    desc.thumb      = thumb_mode;
    if (empty_list) begin
      desc.bupd = 1'b1;
    end else if (!is_load) begin
      desc.bupd = write_back && !s_bit;
    end else begin
      desc.bupd = write_back && !(has_pc && s_bit) && !has_base;
    end
    desc.rstat = is_load && has_pc && s_bit && !empty_list;
    desc.flush = is_load && eff[15];
  end

endmodule

FILE: hdl/bts_queue.sv
// Descriptor queue between the front and back parts.
module bts_queue #(
  parameter int DEPTH = bts_pkg::BTS_QDEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  bts_pkg::bts_desc_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output bts_pkg::bts_desc_t rd_data,
  output logic               empty
);
  import bts_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bts_desc_t     mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: hdl/bts_back.sv
// Back part: steps through one descriptor, one transaction per cycle while the output is empty or popped.
module bts_back (
  input  logic               clk,
  input  logic               rst,
  input  bts_pkg::bts_desc_t q_data,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [31:0]        mem_addr,
  output logic [3:0]         reg_index,
  output logic               load_dir,
  output logic               user_bank,
  output logic               store_new_base,
  output logic [2:0]         pc_add,
  output logic [31:0]        final_base,
  output logic               base_update,
  output logic               restore_status,
  output logic               flush_pipe,
  output logic               last
);
  import bts_pkg::*;

  bts_desc_t   cur;
  logic        busy;
  logic [15:0] mask;
  logic [31:0] addr;
  logic        ovalid;

  logic [3:0]  idx;
  logic [3:0]  reg_sel;
  logic [15:0] mask_next;
  logic        is_last;
  logic        advance;

  // Find the next register to move
  always_comb begin
    idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (mask[i]) begin
        idx = 4'(i);
      end
    end
  end

  assign reg_sel   = cur.descending ? (BTS_PC_REG - idx) : idx;
  assign mask_next = mask & (mask - 16'd1);
  assign is_last   = (mask_next == 16'd0);
  assign advance   = busy && (!ovalid || pop);
  assign q_pop     = !busy && !q_empty;
  assign empty     = !ovalid;

  // Hold the current instruction and walk its list
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (advance && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur  <= q_data;
      mask <= q_data.mask;
      addr <= q_data.start;
    end else if (advance) begin
      mask <= mask_next;
      addr <= cur.descending ? (addr - BTS_WORD_STEP) : (addr + BTS_WORD_STEP);
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (advance) begin
      ovalid <= 1'b1;
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

  // Output register: transaction payload
  always_ff @(posedge clk) begin
    if (advance) begin
      mem_addr       <= addr & BTS_ALIGN_MASK;
      reg_index      <= reg_sel;
      load_dir       <= cur.is_load;
      user_bank      <= cur.ubank;
      store_new_base <= cur.snb_en && (reg_sel == cur.rn);
      if (!cur.is_load && reg_sel == BTS_PC_REG) begin
        pc_add <= cur.thumb ? BTS_PC_ADD_THUMB : BTS_PC_ADD_ARM;
      end else begin
        pc_add <= BTS_PC_ADD_NONE;
      end
      final_base     <= cur.fin;
      base_update    <= is_last && cur.bupd;
      restore_status <= is_last && cur.rstat;
      flush_pipe     <= is_last && cur.flush;
      last           <= is_last;
    end
  end

endmodule
